>>> sv/r2yuv_pkg.sv
// ----------------------------------------------------------------------------
// r2yuv_pkg
// Shared constants, register indexes and helpers for the RGB to YUV 4:2:0
// converter core.
// ----------------------------------------------------------------------------
package r2yuv_pkg;

    // Frame size limits and register widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 4;

    localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_WIDTH_V   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT_V  = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] RESET_WIDTH   = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT  = SIZE_W'(480);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1
    } cfg_index_t;

    // Biased color sums: 17 bits of magnitude plus headroom
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] SUM_BIAS = SUM_W'(128 + 32768);

    // Offsets added after the shift (bias of 32768 in the sum, 128 after the shift, removed here)
    localparam logic [8:0] Y_OFFSET = 9'd16;
    localparam logic [8:0] C_OFFSET = 9'd128;

    // Clamp a frame size to 2..max
    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] hi
    );
        logic [SIZE_W-1:0] r;
        begin
            if (v < MIN_SIZE)
                r = MIN_SIZE;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

    // Drop the low byte, remove the bias, add the offset and saturate
    function automatic logic [PIX_W-1:0] clamp_byte(
        input logic [SUM_W-1:0] s,
        input logic [8:0]       offset
    );
        logic signed [11:0] q;
        logic [PIX_W-1:0]   r;
        begin
            q = $signed({3'b000, s[16:8]}) - 12'sd128 + $signed({3'b000, offset});
            if (q < 12'sd0)
                r = '0;
            else if (q > 12'sd255)
                r = '1;
            else
                r = q[PIX_W-1:0];
            return r;
        end
    endfunction

endpackage

>>> sv/rgb_to_yuv420_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// Converts a raster stream of RGB24 pixels to BT.601 studio-range YUV with
// 4:2:0 chroma decimation and frame position tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, red, green, blue) takes one pixel per
//   request in raster order. Output channel (out_valid / out_stall) returns
//   one result per pixel: luma always, chroma_u / chroma_v with chroma_valid
//   at even column and even row (zero elsewhere), frame_end on the last pixel.
//   A pixel passes the input register, then the color math, then the result
//   register before it shows on the output. Throughput is one pixel per
//   clock while out_stall is low, set by the two-register pipeline (input
//   register, result register) with the color math in between.
//   When the receiver stalls, the result register holds, then the input
//   register fills and in_stall rises; nothing is dropped.
//   Reset empties both stages, zeroes the column and row counters and loads
//   frame_width 640 and frame_height 480. Write frame_width / frame_height
//   through cfg_write, cfg_index, cfg_data only while the stream is idle.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core
    import r2yuv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     red,
    input  logic [PIX_W-1:0]     green,
    input  logic [PIX_W-1:0]     blue,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     luma,
    output logic [PIX_W-1:0]     chroma_u,
    output logic [PIX_W-1:0]     chroma_v,
    output logic                 chroma_valid,
    output logic                 frame_end
);

    // Configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // Position counters
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;

    // Input stage
    logic              s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    logic              s1_cvalid_reg, s1_fend_reg;

    // Result stage
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  luma_reg, cu_reg, cv_reg;
    logic              cvalid_reg, fend_reg;

    // Handshake and control
    logic              in_fire, s1_move, out_free, s1_free;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              last_col, last_row, even_pos;

    // Color sums
    logic [SUM_W-1:0]  y_sum, u_sum, v_sum;

    // Pipeline flow: result stage frees when empty or taken
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_stall = !s1_free;
    assign in_fire  = in_valid && s1_free;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Track frame position of the next pixel
    always_comb
    begin
        w_eff    = clamp_size(width_reg,  MAX_WIDTH_V);
        h_eff    = clamp_size(height_reg, MAX_HEIGHT_V);
        last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= h_eff;
        even_pos = !col_reg[0] && !row_reg[0];
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input stage: capture pixel and its position flags
    assign s1_valid_next = in_fire || (s1_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_red_reg    <= red;
            s1_green_reg  <= green;
            s1_blue_reg   <= blue;
            s1_cvalid_reg <= even_pos;
            s1_fend_reg   <= last_col && last_row;
        end
    end

    // Biased BT.601 sums, all kept non-negative
    always_comb
    begin
        y_sum = SUM_W'(s1_red_reg) * SUM_W'(66) + SUM_W'(s1_green_reg) * SUM_W'(129)
              + SUM_W'(s1_blue_reg) * SUM_W'(25) + SUM_BIAS;
        u_sum = SUM_W'(s1_blue_reg) * SUM_W'(112) + SUM_BIAS
              - SUM_W'(s1_red_reg) * SUM_W'(38) - SUM_W'(s1_green_reg) * SUM_W'(74);
        v_sum = SUM_W'(s1_red_reg) * SUM_W'(112) + SUM_BIAS
              - SUM_W'(s1_green_reg) * SUM_W'(94) - SUM_W'(s1_blue_reg) * SUM_W'(18);
    end

    // Result stage: clamp and hold until taken
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            luma_reg   <= clamp_byte(y_sum, Y_OFFSET);
            cu_reg     <= s1_cvalid_reg ? clamp_byte(u_sum, C_OFFSET) : '0;
            cv_reg     <= s1_cvalid_reg ? clamp_byte(v_sum, C_OFFSET) : '0;
            cvalid_reg <= s1_cvalid_reg;
            fend_reg   <= s1_fend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_u     = cu_reg;
    assign chroma_v     = cv_reg;
    assign chroma_valid = cvalid_reg;
    assign frame_end    = fend_reg;

`ifndef SYNTHESIS
    // A stalled result keeps the input stage parked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=>
            (s1_valid_reg && $stable(s1_red_reg) && $stable(s1_fend_reg)))
        else $error("input stage lost or changed under output stall");

    // Column advances by one on an accepted pixel that is not last in line
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !last_col) |=> (col_reg == $past(col_reg) + COL_W'(1)))
        else $error("column counter did not advance");

    // Empty input stage never back-pressures
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("stall raised with empty input stage");

    // Dropped chroma reads as zero
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cvalid_reg) |-> (cu_reg == '0 && cv_reg == '0))
        else $error("chroma not zero on a decimated sample");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB to YUV 4:2:0 converter core. A clocked
// driver feeds pixels from a pending queue, a clocked monitor compares every
// result against a BT.601 integer model of the core, and an initial block
// walks through frame sizes (reset, minimum, odd, clamped, changed mid-line
// and mid-frame) with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import r2yuv_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
        logic             chroma_valid;
        logic             frame_end;
    } yuv_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;

    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] red   = '0;
    logic [PIX_W-1:0] green = '0;
    logic [PIX_W-1:0] blue  = '0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic             chroma_valid;
    logic             frame_end;

    rgb_pixel_t  pending_pixels[$];
    yuv_result_t predicted_yuv[$];

    // Shadow of the frame size registers and of the raster position
    logic [SIZE_W-1:0] width_shadow  = RESET_WIDTH;
    logic [SIZE_W-1:0] height_shadow = RESET_HEIGHT;
    int col_pos = 0;
    int row_pos = 0;

    int mismatches = 0;
    bit idle_on = 1'b1;
    int long_hold_go = 0;
    int long_hold_seen = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int recv_hold = 0;

    rgb_to_yuv420_converter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .luma         (luma),
        .chroma_u     (chroma_u),
        .chroma_v     (chroma_v),
        .chroma_valid (chroma_valid),
        .frame_end    (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Effective frame size after the 2..max clamp
    function automatic int size_used(input logic [SIZE_W-1:0] v, input int hi);
        int s;
        begin
            s = int'(v);
            if (s < 2)
                s = 2;
            else if (s > hi)
                s = hi;
            return s;
        end
    endfunction

    function automatic logic [PIX_W-1:0] sat_byte(input int v);
        logic [PIX_W-1:0] r;
        begin
            if (v < 0)
                r = '0;
            else if (v > 255)
                r = '1;
            else
                r = v[PIX_W-1:0];
            return r;
        end
    endfunction

    // Convert one accepted pixel and advance the raster position
    task automatic predict_yuv(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b);
        int rr;
        int gg;
        int bb;
        int w;
        int h;
        bit keep;
        bit last_col;
        bit last_row;
        yuv_result_t res;
        begin
            rr = int'(r);
            gg = int'(g);
            bb = int'(b);
            w = size_used(width_shadow, MAX_WIDTH);
            h = size_used(height_shadow, MAX_HEIGHT);
            keep = (col_pos % 2 == 0) && (row_pos % 2 == 0);
            last_col = (col_pos + 1) >= w;
            last_row = (row_pos + 1) >= h;

            res.luma = sat_byte(((66 * rr + 129 * gg + 25 * bb + 128) >>> 8) + 16);
            res.chroma_u = keep ?
                sat_byte(((-38 * rr - 74 * gg + 112 * bb + 128) >>> 8) + 128) : '0;
            res.chroma_v = keep ?
                sat_byte(((112 * rr - 94 * gg - 18 * bb + 128) >>> 8) + 128) : '0;
            res.chroma_valid = keep;
            res.frame_end = last_col && last_row;
            predicted_yuv.push_back(res);

            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = col_pos + 1;
            end
        end
    endtask

    // Driver: present pending pixels, record each accepted request
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        rgb_pixel_t px;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_yuv(red, green, blue);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    px = pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    red <= px.red;
                    green <= px.green;
                    blue <= px.blue;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result, then pick the next stall state
    always @(posedge clk or negedge rst_n)
    begin : check_results
        yuv_result_t exp_res;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_yuv.size() == 0)
                begin
                    $error("unexpected result: luma %0d", luma);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    exp_res = predicted_yuv.pop_front();
                    if (luma !== exp_res.luma)
                    begin
                        $error("luma: expected %0d, actual %0d", exp_res.luma, luma);
                        mismatches = mismatches + 1;
                    end
                    if (chroma_u !== exp_res.chroma_u)
                    begin
                        $error("chroma_u: expected %0d, actual %0d", exp_res.chroma_u, chroma_u);
                        mismatches = mismatches + 1;
                    end
                    if (chroma_v !== exp_res.chroma_v)
                    begin
                        $error("chroma_v: expected %0d, actual %0d", exp_res.chroma_v, chroma_v);
                        mismatches = mismatches + 1;
                    end
                    if (chroma_valid !== exp_res.chroma_valid)
                    begin
                        $error("chroma_valid: expected %0d, actual %0d",
                               exp_res.chroma_valid, chroma_valid);
                        mismatches = mismatches + 1;
                    end
                    if (frame_end !== exp_res.frame_end)
                    begin
                        $error("frame_end: expected %0d, actual %0d",
                               exp_res.frame_end, frame_end);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (long_hold_go != long_hold_seen)
            begin
                long_hold_seen = long_hold_go;
                recv_hold = LONG_HOLD_CYCLES;
            end
            if (recv_hold > 0)
            begin
                recv_hold = recv_hold - 1;
                out_stall <= 1'b1;
            end
            else if (recv_stall > 0)
            begin
                recv_stall = recv_stall - 1;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_pixel(input int r, input int g, input int b);
        rgb_pixel_t px;
        begin
            px.red = r[PIX_W-1:0];
            px.green = g[PIX_W-1:0];
            px.blue = b[PIX_W-1:0];
            pending_pixels.push_back(px);
        end
    endtask

    // Random component, biased toward the rails
    function automatic int rand_level();
        int sel;
        begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                return 0;
            else if (sel == 1)
                return 255;
            else
                return $urandom_range(0, 255);
        end
    endfunction

    task automatic push_random(input int n);
        begin
            repeat (n)
                push_pixel(rand_level(), rand_level(), rand_level());
        end
    endtask

    // Hold until every pixel is sent and every result has come back
    task automatic wait_drained();
        begin
            @(negedge clk);
            while (pending_pixels.size() != 0 || predicted_yuv.size() != 0 || in_valid)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value[SIZE_W-1:0];
            @(posedge clk);
            cfg_write <= 1'b0;
            if (idx == CFG_FRAME_WIDTH)
                width_shadow = value[SIZE_W-1:0];
            else if (idx == CFG_FRAME_HEIGHT)
                height_shadow = value[SIZE_W-1:0];
        end
    endtask

    task automatic set_frame(input int w, input int h);
        begin
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Corners of the color cube, mid gray and a small value at the reset frame size
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(255, 0, 0);
        push_pixel(0, 255, 0);
        push_pixel(0, 0, 255);
        push_pixel(255, 255, 0);
        push_pixel(0, 255, 255);
        push_pixel(255, 0, 255);
        push_pixel(128, 128, 128);
        push_pixel(1, 2, 3);
        wait_drained();

        // Smallest frame: chroma and frame end every few pixels
        set_frame(2, 2);
        push_pixel(255, 0, 0);
        push_pixel(0, 0, 255);
        push_pixel(0, 255, 0);
        push_pixel(255, 255, 255);
        push_pixel(0, 0, 255);
        push_pixel(255, 0, 0);
        push_pixel(0, 0, 0);
        push_pixel(0, 255, 255);
        wait_drained();

        // Sizes below the minimum clamp to 2
        set_frame(0, 1);
        push_random(40);
        wait_drained();

        // Odd sizes
        set_frame(3, 5);
        push_random(300);
        wait_drained();

        // Receiver holds off while the sender keeps offering
        set_frame(8, 6);
        push_random(150);
        long_hold_go = long_hold_go + 1;
        push_random(150);
        wait_drained();
        push_random(200);
        wait_drained();

        // Oversized width clamps; unused index is ignored
        set_frame(8191, 4);
        write_reg(CFG_NO_REG, 'h1555);
        write_reg(CFG_NO_REG, 'h0AAA);
        push_random(150);
        wait_drained();

        // Narrow the line with the column far past its new end
        write_reg(CFG_FRAME_WIDTH, 4);
        push_random(100);
        wait_drained();

        // Oversized height clamps
        set_frame(2, 8191);
        push_random(200);
        wait_drained();
        set_frame(4096, 4096);
        push_random(50);
        wait_drained();

        // Shrink the frame with the row past its new end
        write_reg(CFG_FRAME_HEIGHT, 2);
        write_reg(CFG_FRAME_WIDTH, 6);
        push_random(200);
        wait_drained();

        // Full rate on both sides to finish
        set_frame(4, 2);
        idle_on = 1'b0;
        push_random(500);
        wait_drained();
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
